// File: rtl/core/afl_pkg.sv
// Package: shared types and constants for the aspect-fit letterbox block.
`timescale 1ns / 1ps
`default_nettype none
package afl_pkg;

  localparam int DIM_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  // input register, product, select, one cell per quotient bit, output register
  localparam int LATENCY = DIM_BITS + 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_COLS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_ROWS = 2'd1;

  typedef struct packed {
    logic [DIM_BITS-1:0] src_cols;
    logic [DIM_BITS-1:0] src_rows;
  } afl_in_t;

  typedef struct packed {
    logic                fit_ok;
    logic [DIM_BITS-1:0] dest_x;
    logic [DIM_BITS-1:0] dest_y;
    logic [DIM_BITS-1:0] dest_cols;
    logic [DIM_BITS-1:0] dest_rows;
  } afl_out_t;

  typedef struct packed {
    logic                zero;
    logic                cols_limit;
    logic [DIM_BITS-1:0] pc;
    logic [DIM_BITS-1:0] pr;
  } afl_side_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] rem;
    logic [DIM_BITS-1:0] num_lo;
    logic [DIM_BITS-1:0] divisor;
    logic [DIM_BITS-1:0] quo;
    afl_side_t           side;
  } afl_cell_t;

endpackage
`default_nettype wire

// File: rtl/core/aspect_fit_letterbox.sv
// Top level: aspect-ratio-preserving letterbox fit, pipelined divider chain.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | start, busy          | src    (src_cols, src_rows)
//  result   | done (one-cycle)     | result (fit_ok, dest_x/y, dest_cols/rows)
//  config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One transaction accepted per cycle while busy is low; each passes the input,
// product and select registers, the divider chain and the output register to done.
// The divider chain holds one cell per quotient bit.
// busy stays high until the first edge without rst; rst clears all valid flags.
// The receiver cannot stall; done pulses once per transaction.
`timescale 1ns / 1ps
`default_nettype none
module aspect_fit_letterbox (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire afl_pkg::afl_in_t                  src,
  output logic                                   done,
  output afl_pkg::afl_out_t                      result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [afl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [afl_pkg::DIM_BITS-1:0]      cfg_data
);
  import afl_pkg::*;

  logic [DIM_BITS-1:0] panel_cols;
  logic [DIM_BITS-1:0] panel_rows;
  logic                accept;

  logic                chain_vld  [DIM_BITS+1];
  afl_cell_t           chain_data [DIM_BITS+1];

  afl_cell_t           last;
  logic [DIM_BITS-1:0] dc, dr;
  afl_out_t            result_next;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      panel_cols <= '0;
      panel_rows <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PANEL_COLS: panel_cols <= cfg_data;
          REG_PANEL_ROWS: panel_rows <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  afl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .src        (src),
    .panel_cols (panel_cols),
    .panel_rows (panel_rows),
    .vld_o      (chain_vld[0]),
    .data_o     (chain_data[0])
  );

  for (genvar i = 0; i < DIM_BITS; i++) begin : g_cell
    afl_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .vld_i  (chain_vld[i]),
      .data_i (chain_data[i]),
      .vld_o  (chain_vld[i+1]),
      .data_o (chain_data[i+1])
    );
  end

  always_comb begin
    last = chain_data[DIM_BITS];
    if (last.side.cols_limit) begin
      dc = last.side.pc;
      dr = last.quo;
    end else begin
      dc = last.quo;
      dr = last.side.pr;
    end
    if (last.side.zero) begin
      result_next = '0;
    end else begin
      result_next.fit_ok    = (dc != '0) && (dr != '0);
      result_next.dest_x    = (last.side.pc - dc) >> 1;
      result_next.dest_y    = (last.side.pr - dr) >> 1;
      result_next.dest_cols = dc;
      result_next.dest_rows = dr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_vld[DIM_BITS];
    end
    result <= result_next;
  end

endmodule
`default_nettype wire

// File: rtl/core/afl_div_cell.sv
// Divider cell: one restoring quotient bit per cycle, passes its transaction on.
`timescale 1ns / 1ps
`default_nettype none
module afl_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              vld_i,
  input  wire afl_pkg::afl_cell_t data_i,
  output logic                   vld_o,
  output afl_pkg::afl_cell_t     data_o
);
  import afl_pkg::*;

  logic [DIM_BITS:0]   trial;
  logic [DIM_BITS:0]   diff;
  logic                ge;
  afl_cell_t           data_next;

  always_comb begin
    trial = {data_i.rem, data_i.num_lo[DIM_BITS-1]};
    diff  = trial - {1'b0, data_i.divisor};
    ge    = (trial >= {1'b0, data_i.divisor});
    data_next         = data_i;
    data_next.rem     = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    data_next.num_lo  = {data_i.num_lo[DIM_BITS-2:0], 1'b0};
    data_next.quo     = {data_i.quo[DIM_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
    data_o <= data_next;
  end

endmodule
`default_nettype wire

// File: rtl/core/afl_front.sv
// Front end: input capture, cross products, limiting-axis select.
`timescale 1ns / 1ps
`default_nettype none
module afl_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire afl_pkg::afl_in_t              src,
  input  wire logic [afl_pkg::DIM_BITS-1:0]  panel_cols,
  input  wire logic [afl_pkg::DIM_BITS-1:0]  panel_rows,
  output logic                               vld_o,
  output afl_pkg::afl_cell_t                 data_o
);
  import afl_pkg::*;

  logic                  a_vld;
  logic [DIM_BITS-1:0]   a_sc, a_sr, a_pc, a_pr;
  logic                  a_zero;

  logic                  b_vld;
  logic [DIM_BITS-1:0]   b_sc, b_sr, b_pc, b_pr;
  logic                  b_zero;
  logic [2*DIM_BITS-1:0] b_prod_c, b_prod_r;

  logic                  cols_limit;
  logic [2*DIM_BITS-1:0] num;
  afl_cell_t             data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      a_vld <= accept;
      b_vld <= a_vld;
      vld_o <= b_vld;
    end
    a_sc   <= src.src_cols;
    a_sr   <= src.src_rows;
    a_pc   <= panel_cols;
    a_pr   <= panel_rows;
    a_zero <= (src.src_cols == '0) || (src.src_rows == '0) ||
              (panel_cols == '0) || (panel_rows == '0);

    b_sc     <= a_sc;
    b_sr     <= a_sr;
    b_pc     <= a_pc;
    b_pr     <= a_pr;
    b_zero   <= a_zero;
    b_prod_c <= (2*DIM_BITS)'(a_pc) * (2*DIM_BITS)'(a_sr);
    b_prod_r <= (2*DIM_BITS)'(a_pr) * (2*DIM_BITS)'(a_sc);

    data_o <= data_next;
  end

  always_comb begin
    cols_limit = (b_prod_c <= b_prod_r);
    num        = cols_limit ? b_prod_c : b_prod_r;
    data_next.rem             = num[2*DIM_BITS-1:DIM_BITS];
    data_next.num_lo          = num[DIM_BITS-1:0];
    data_next.divisor         = cols_limit ? b_sc : b_sr;
    data_next.quo             = '0;
    data_next.side.zero       = b_zero;
    data_next.side.cols_limit = cols_limit;
    data_next.side.pc         = b_pc;
    data_next.side.pr         = b_pr;
  end

endmodule
`default_nettype wire

// File: rtl/core/afl_checker.sv
// Port-level checker for the aspect-fit letterbox block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module afl_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire afl_pkg::afl_out_t                 result,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready
);
  import afl_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("transaction accepted without a result after the pipeline latency");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching accepted transaction");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && result.fit_ok) |-> (result.dest_cols != '0 && result.dest_rows != '0))
    else $error("fit_ok set on an empty rectangle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.dest_cols == '0 && result.dest_rows == '0) |->
      (!result.fit_ok && result.dest_x == '0 && result.dest_y == '0))
    else $error("zero-size result carries nonzero offsets");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind aspect_fit_letterbox afl_checker u_afl_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the aspect-fit letterbox block: queued stimulus, predictor, monitor.
module testbench;
  import afl_pkg::*;

  typedef enum logic {REQ_FIT, REQ_PANEL} req_kind_t;

  typedef struct packed {
    req_kind_t               kind;
    afl_in_t                 src;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DIM_BITS-1:0]     data;
    logic [3:0]              gap;
  } fit_req_t;

  // unused register slots; writes to them must not change the panel
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
  localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 95;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  afl_in_t                 src = '0;
  logic                    done;
  afl_out_t                result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DIM_BITS-1:0]     cfg_data = '0;

  fit_req_t            fit_requests[$];
  afl_out_t            expected_fits[$];
  logic [DIM_BITS-1:0] panel_w = '0;
  logic [DIM_BITS-1:0] panel_h = '0;
  int unsigned         mismatch_count = 0;
  int unsigned         idle_left = 0;
  int unsigned         settle_count = 0;

  aspect_fit_letterbox uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .src       (src),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [2*DIM_BITS-1:0] widen(logic [DIM_BITS-1:0] v);
    return {{DIM_BITS{1'b0}}, v};
  endfunction

  function automatic afl_out_t letterbox_fit(afl_in_t s, logic [DIM_BITS-1:0] pw,
                                             logic [DIM_BITS-1:0] ph);
    afl_out_t            fit;
    logic [2*DIM_BITS-1:0] cross_w;
    logic [2*DIM_BITS-1:0] cross_h;
    logic [2*DIM_BITS-1:0] scaled;
    fit = '0;
    if (s.src_cols == '0 || s.src_rows == '0 || pw == '0 || ph == '0) return fit;
    cross_w = widen(pw) * widen(s.src_rows);
    cross_h = widen(ph) * widen(s.src_cols);
    if (cross_w <= cross_h) begin
      fit.dest_cols = pw;
      scaled = cross_w / widen(s.src_cols);
      fit.dest_rows = scaled[DIM_BITS-1:0];
    end else begin
      fit.dest_rows = ph;
      scaled = cross_h / widen(s.src_rows);
      fit.dest_cols = scaled[DIM_BITS-1:0];
    end
    fit.dest_x = (pw - fit.dest_cols) >> 1;
    fit.dest_y = (ph - fit.dest_rows) >> 1;
    fit.fit_ok = (fit.dest_cols != '0) && (fit.dest_rows != '0);
    return fit;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_fit(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h, logic [3:0] gap);
    fit_req_t req;
    req = '0;
    req.kind = REQ_FIT;
    req.src.src_cols = w;
    req.src.src_rows = h;
    req.gap = gap;
    fit_requests.push_back(req);
  endtask

  task automatic queue_panel(logic [CFG_IDX_BITS-1:0] index, logic [DIM_BITS-1:0] data);
    fit_req_t req;
    req = '0;
    req.kind = REQ_PANEL;
    req.index = index;
    req.data = data;
    fit_requests.push_back(req);
  endtask

  function automatic afl_in_t random_source(logic [DIM_BITS-1:0] pw, logic [DIM_BITS-1:0] ph);
    afl_in_t     s;
    int unsigned d;
    s.src_cols = DIM_BITS'($urandom);
    s.src_rows = DIM_BITS'($urandom);
    case ($urandom_range(0, 9))
      3, 4: begin
        s.src_cols = DIM_BITS'($urandom_range(1, 64));
        s.src_rows = DIM_BITS'($urandom_range(1, 64));
      end
      5, 6: begin
        // panel shape scaled down, off by at most one pixel per axis
        d = $urandom_range(1, 8);
        s.src_cols = DIM_BITS'(int'(pw) / d + $urandom_range(0, 2) - 1);
        s.src_rows = DIM_BITS'(int'(ph) / d + $urandom_range(0, 2) - 1);
      end
      7: s.src_cols = $urandom_range(0, 1) ? DIM_MAX : DIM_ONE;
      8: s.src_rows = $urandom_range(0, 1) ? DIM_MAX : DIM_ONE;
      9: begin
        if ($urandom_range(0, 1)) s.src_cols = '0;
        else s.src_rows = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    fit_req_t req;
    logic     start_nxt;
    logic     cfg_nxt;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      idle_left = 0;
      settle_count = 0;
    end else begin
      if (start && !busy) expected_fits.push_back(letterbox_fit(src, panel_w, panel_h));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PANEL_COLS: panel_w = cfg_data;
          REG_PANEL_ROWS: panel_h = cfg_data;
          default: ;
        endcase
      end
      if (expected_fits.size() == 0 && !start) begin
        if (settle_count < SETTLE_CYCLES) settle_count++;
      end else begin
        settle_count = 0;
      end
      start_nxt = start && busy;
      cfg_nxt = cfg_valid && !cfg_ready;
      if (!start_nxt && !cfg_nxt) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (fit_requests.size() != 0) begin
          req = fit_requests[0];
          if (req.kind == REQ_FIT) begin
            void'(fit_requests.pop_front());
            start_nxt = 1'b1;
            src <= req.src;
            idle_left = req.gap;
          end else if (settle_count >= SETTLE_CYCLES) begin
            // panel writes only once the pipeline has drained
            void'(fit_requests.pop_front());
            cfg_nxt = 1'b1;
            cfg_index <= req.index;
            cfg_data <= req.data;
          end
        end
      end
      start <= start_nxt;
      cfg_valid <= cfg_nxt;
    end
  end

  // monitor
  always @(posedge clk) begin
    afl_out_t want;
    if (!rst && done) begin
      if (expected_fits.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = expected_fits.pop_front();
        if (result.fit_ok !== want.fit_ok)
          report_mismatch($sformatf("fit_ok got %b expected %b", result.fit_ok, want.fit_ok));
        if (result.dest_x !== want.dest_x)
          report_mismatch($sformatf("dest_x got %0d expected %0d", result.dest_x, want.dest_x));
        if (result.dest_y !== want.dest_y)
          report_mismatch($sformatf("dest_y got %0d expected %0d", result.dest_y, want.dest_y));
        if (result.dest_cols !== want.dest_cols)
          report_mismatch($sformatf("dest_cols got %0d expected %0d",
                                    result.dest_cols, want.dest_cols));
        if (result.dest_rows !== want.dest_rows)
          report_mismatch($sformatf("dest_rows got %0d expected %0d",
                                    result.dest_rows, want.dest_rows));
      end
    end
  end

  initial begin
    logic [DIM_BITS-1:0] plan_w;
    logic [DIM_BITS-1:0] plan_h;
    afl_in_t             s;
    bit                  burst;

    // panel still zero after reset
    queue_fit(16'd1920, 16'd1080, 4'd0);
    queue_fit(DIM_MAX, DIM_MAX, 4'd3);
    queue_panel(REG_SPARE_A, 16'd777);
    queue_panel(REG_SPARE_B, DIM_MAX);
    queue_panel(REG_PANEL_COLS, 16'd1920);
    queue_fit(16'd640, 16'd480, 4'd0);
    queue_panel(REG_SPARE_B, 16'd5);
    queue_panel(REG_PANEL_ROWS, 16'd1080);
    queue_fit('0, '0, 4'd0);
    queue_fit('0, 16'd480, 4'd0);
    queue_fit(16'd640, '0, 4'd1);
    queue_fit(DIM_ONE, DIM_ONE, 4'd0);
    queue_fit(DIM_MAX, DIM_MAX, 4'd0);
    queue_fit(DIM_MAX, DIM_ONE, 4'd2);
    queue_fit(DIM_ONE, DIM_MAX, 4'd0);
    queue_fit(16'd65535, 16'd2, 4'd0);
    queue_fit(16'd16, 16'd9, 4'd0);
    queue_fit(16'd1920, 16'd1080, 4'd14);
    queue_fit(16'd640, 16'd480, 4'd0);
    queue_fit(16'd2560, 16'd1080, 4'd0);
    queue_fit(16'd1280, 16'd1024, 4'd0);
    queue_fit(16'd3, 16'd2, 4'd0);
    queue_fit(16'd65534, 16'd65533, 4'd0);
    queue_panel(REG_PANEL_COLS, DIM_MAX);
    queue_panel(REG_PANEL_ROWS, DIM_MAX);
    queue_fit(DIM_MAX, DIM_MAX, 4'd0);
    queue_fit(DIM_ONE, DIM_MAX, 4'd0);
    queue_fit(DIM_MAX, 16'd65534, 4'd0);

    burst = 1'b0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin plan_w = DIM_MAX; plan_h = DIM_MAX; end
        1: begin plan_w = DIM_ONE; plan_h = DIM_ONE; end
        2: begin plan_w = DIM_MAX; plan_h = DIM_ONE; end
        3: begin plan_w = DIM_ONE; plan_h = DIM_MAX; end
        4: begin plan_w = '0; plan_h = DIM_BITS'($urandom); end
        5: begin
          plan_w = DIM_BITS'($urandom_range(1, 16));
          plan_h = DIM_BITS'($urandom_range(1, 16));
        end
        default: begin plan_w = DIM_BITS'($urandom); plan_h = DIM_BITS'($urandom); end
      endcase
      queue_panel(REG_PANEL_COLS, plan_w);
      queue_panel(REG_PANEL_ROWS, plan_h);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 15) == 0) burst = !burst;
        s = random_source(plan_w, plan_h);
        queue_fit(s.src_cols, s.src_rows, burst ? 4'd0 : 4'($urandom_range(0, 14)));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (fit_requests.size() != 0 || start || cfg_valid) @(posedge clk);
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/core/afl_pkg.sv
rtl/core/afl_div_cell.sv
rtl/core/afl_front.sv
rtl/core/aspect_fit_letterbox.sv
rtl/core/afl_checker.sv
dv/testbench.sv
